[design/rsmms_pkg.sv]
// ----------------------------------------------------------------------------
// rsmms_pkg
// Shared widths, codes and reset values for the running statistics block.
// ----------------------------------------------------------------------------
package rsmms_pkg;
  localparam int SampleWidth = 32;
  localparam int CountWidth  = 32;
  localparam int IdWidth     = 32;
  localparam int MeanWidth   = 48;
  localparam int MsqWidth    = 64;
  localparam int DivWidth    = 64;
  localparam int CfgAddrWidth = 1;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;
  localparam logic [CfgAddrWidth-1:0] REG_TOLERANCE = '0;

  localparam logic [31:0] MIN_RESET = 32'h7FFF_FFFF;
  localparam logic [31:0] ID_NONE   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic                start;
    logic [DivWidth-1:0] num;
    logic [CountWidth-1:0] den;
  } div_req_t;
endpackage

[design/rsmms_div.sv]
// ----------------------------------------------------------------------------
// rsmms_div
// Bit-serial restoring divider: unsigned 64 by 32 bits, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module rsmms_div import rsmms_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  div_req_t              req,
  output logic                  done,
  output logic [DivWidth-1:0]   quot
);
  logic [DivWidth-1:0]   q_r, q_nxt;
  logic [CountWidth:0]   rem_r, rem_nxt;
  logic [CountWidth-1:0] den_r;
  logic [6:0]            cnt_r;
  logic                  busy_r, done_r;
  logic [CountWidth:0]   trial;

  always_comb begin
    trial   = {rem_r[CountWidth-1:0], q_r[DivWidth-1]};
    rem_nxt = trial;
    q_nxt   = {q_r[DivWidth-2:0], 1'b0};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = trial - {1'b0, den_r};
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'(DivWidth);
        q_r    <= req.num;
        rem_r  <= '0;
        den_r  <= req.den;
      end else if (busy_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

[design/rsmms_sqrt.sv]
// ----------------------------------------------------------------------------
// rsmms_sqrt
// Digit-serial integer square root of a 64-bit value, two bits per cycle.
// ----------------------------------------------------------------------------
module rsmms_sqrt import rsmms_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [MsqWidth-1:0] val,
  output logic                done,
  output logic [31:0]         root
);
  logic [MsqWidth-1:0] v_r;
  logic [33:0]         rem_r, rem_nxt, trial;
  logic [31:0]         q_r, q_nxt;
  logic [5:0]          cnt_r;
  logic                busy_r, done_r;

  always_comb begin
    rem_nxt = {rem_r[31:0], v_r[MsqWidth-1 -: 2]};
    trial   = {q_r, 2'b01};
    q_nxt   = {q_r[30:0], 1'b0};
    if (rem_nxt >= trial) begin
      rem_nxt  = rem_nxt - trial;
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
        v_r    <= val;
        rem_r  <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        v_r   <= {v_r[MsqWidth-3:0], 2'b00};
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = q_r;
endmodule

[design/running_stats_min_max_stddev.sv]
// ----------------------------------------------------------------------------
// running_stats_min_max_stddev
// Running count, mean, sample standard deviation and extremes over Q16.16.
// ----------------------------------------------------------------------------
// One beat in, one result beat out. For a sample beat the mean and
// mean-of-squares updates and the division by n-1 each pass one bit per
// cycle through a shared 64-bit serial divider, the square of the mean is
// formed on a 16x16 multiplier, and the square root takes two radicand bits
// per cycle; a count of one or less ends the beat after the mean-of-squares
// update. A new input is taken once the result register is free.
module running_stats_min_max_stddev import rsmms_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // sample[31:0], element_tag[62:32], zero
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  // mean[31:0] std_dev[63:32] min[95:64] min_tag[127:96] max[159:128]
  // max_tag[191:160] count[223:192]
  output logic [223:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [CfgAddrWidth+1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  typedef enum logic [3:0] {
    S_IDLE, S_DMEAN, S_WMEAN, S_DMSQ, S_WMSQ, S_SQ, S_DVAR, S_WVAR,
    S_SQRT, S_WSQRT, S_OUT
  } state_t;

  state_t state_r;
  logic [15:0] tol_r;
  logic [CountWidth-1:0] cnt_r;
  logic signed [MeanWidth-1:0] mean_r;
  logic [MsqWidth-1:0] msq_r;
  logic signed [31:0] min_r, max_r, s_r;
  logic [31:0] min_id_r, max_id_r;
  logic neg_r;
  logic [MsqWidth-1:0] acc_r, d_r;
  logic [3:0] sqi_r;
  logic [223:0] odata_r;
  logic ovalid_r;

  div_req_t dreq;
  logic ddone, sqdone, sqstart;
  logic [DivWidth-1:0] dquot;
  logic [31:0] root;

  rsmms_div u_div (.clk, .rst_n, .req(dreq), .done(ddone), .quot(dquot));
  rsmms_sqrt u_sqrt (.clk, .rst_n, .start(sqstart), .val(d_r + dquot),
                     .done(sqdone), .root(root));

  logic accept, cfg_wr;
  assign accept = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE) && !ovalid_r;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[CfgAddrWidth+1:2] == REG_TOLERANCE) ? {16'h0, tol_r} : '0;

  // signed deltas and magnitudes
  logic signed [MeanWidth:0] dm;
  logic signed [MsqWidth:0] dq;
  logic [MsqWidth-1:0] s2;
  logic [MeanWidth-1:0] am;
  logic [15:0] ma, mb;
  logic [31:0] prod;
  assign dm = {{(MeanWidth-47){s_r[31]}}, s_r, 16'h0} - {mean_r[MeanWidth-1], mean_r};
  assign s2 = 64'($signed(s_r) * $signed(s_r));
  assign dq = {1'b0, s2} - {1'b0, msq_r};
  assign am = mean_r[MeanWidth-1] ? 48'(-mean_r) : 48'(mean_r);
  // partial products of am^2 >> 32: am = h*2^32 + m*2^16 + l
  always_comb begin
    case (sqi_r)
      4'd0: begin ma = am[47:32]; mb = am[47:32]; end
      4'd1, 4'd2: begin ma = am[47:32]; mb = am[31:16]; end
      4'd3, 4'd4: begin ma = am[47:32]; mb = am[15:0]; end
      4'd5: begin ma = am[31:16]; mb = am[31:16]; end
      4'd6, 4'd7: begin ma = am[31:16]; mb = am[15:0]; end
      default: begin ma = am[15:0]; mb = am[15:0]; end
    endcase
  end
  assign prod = ma * mb;
  // partial product placed at its weight within the 96-bit square
  logic [95:0] term;
  always_comb begin
    case (sqi_r)
      4'd0: term = {prod, 64'h0};
      4'd1, 4'd2: term = {16'h0, prod, 48'h0};
      4'd3, 4'd4, 4'd5: term = {32'h0, prod, 32'h0};
      4'd6, 4'd7: term = {48'h0, prod, 16'h0};
      default: term = {64'h0, prod};
    endcase
  end
  // low-order carry: exact floor needs low terms together
  logic [65:0] lowsum_r;
  logic [MsqWidth-1:0] sq;
  assign sq = acc_r + 64'(lowsum_r[65:32]);

  logic signed [31:0] ns;
  logic [31:0] nid;
  logic signed [33:0] tol_x;
  assign ns = $signed(in_tdata[31:0]);
  assign nid = {1'b0, in_tdata[62:32]};
  assign tol_x = {18'h0, tol_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tol_r <= '0;
      cnt_r <= '0; mean_r <= '0; msq_r <= '0;
      min_r <= MIN_RESET; max_r <= '0; min_id_r <= ID_NONE; max_id_r <= ID_NONE;
      ovalid_r <= 1'b0;
      dreq <= '0; sqstart <= 1'b0;
    end else begin
      dreq.start <= 1'b0;
      sqstart <= 1'b0;
      if (cfg_wr && cfg_paddr[CfgAddrWidth+1:2] == REG_TOLERANCE) tol_r <= cfg_pwdata[15:0];
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (accept) begin
          if (in_tuser == OP_CLEAR) begin
            cnt_r <= '0; mean_r <= '0; msq_r <= '0;
            min_r <= MIN_RESET; max_r <= '0; min_id_r <= ID_NONE; max_id_r <= ID_NONE;
            state_r <= S_OUT;
          end else begin
            s_r <= ns;
            if (cnt_r != '1) cnt_r <= cnt_r + 1'b1;
            if (cnt_r == '0) begin
              min_r <= ns; max_r <= ns; min_id_r <= nid; max_id_r <= nid;
            end else if (34'(ns) > 34'(max_r) + tol_x) begin
              max_r <= ns; max_id_r <= nid;
            end else if (34'(ns) + tol_x < 34'(min_r)) begin
              min_r <= ns; min_id_r <= nid;
            end
            state_r <= S_DMEAN;
          end
        end
        S_DMEAN: begin
          neg_r <= dm[MeanWidth];
          dreq.start <= 1'b1;
          dreq.num <= 64'(dm[MeanWidth] ? -dm : dm);
          dreq.den <= cnt_r;
          state_r <= S_WMEAN;
        end
        S_WMEAN: if (ddone) begin
          mean_r <= neg_r ? mean_r - 48'(dquot) : mean_r + 48'(dquot);
          state_r <= S_DMSQ;
        end
        S_DMSQ: begin
          neg_r <= dq[MsqWidth];
          dreq.start <= 1'b1;
          dreq.num <= 64'(dq[MsqWidth] ? -dq : dq);
          dreq.den <= cnt_r;
          state_r <= S_WMSQ;
        end
        S_WMSQ: if (ddone) begin
          msq_r <= neg_r ? msq_r - dquot : msq_r + dquot;
          acc_r <= '0; lowsum_r <= '0; sqi_r <= '0;
          state_r <= (cnt_r <= 1) ? S_OUT : S_SQ;
        end
        S_SQ: begin
          acc_r <= acc_r + term[95:32];
          lowsum_r <= lowsum_r + 66'(term[31:0]);
          if (sqi_r == 4'd8) state_r <= S_DVAR;
          sqi_r <= sqi_r + 4'd1;
        end
        S_DVAR: begin
          d_r <= (msq_r >= sq) ? msq_r - sq : sq - msq_r;
          dreq.start <= 1'b1;
          dreq.num <= (msq_r >= sq) ? msq_r - sq : sq - msq_r;
          dreq.den <= cnt_r - 1'b1;
          state_r <= S_WVAR;
        end
        S_WVAR: if (ddone) begin
          sqstart <= 1'b1;
          state_r <= S_WSQRT;
        end
        S_WSQRT: if (sqdone) state_r <= S_OUT;
        S_OUT: begin
          odata_r <= {cnt_r, max_id_r, max_r, min_id_r, min_r,
                      (cnt_r <= 1) ? 32'h0 : root, mean_r[47:16]};
          ovalid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = odata_r;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped");
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && cnt_r != '0 && tol_r == '0) |-> (min_r <= max_r))
    else $error("extremes crossed");
`endif
endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for running_stats_min_max_stddev.
// Sends add and clear beats through the input stream and compares every
// result beat field by field against a predictor of count, mean, standard
// deviation and the extremes. The run goes through several tolerance
// settings, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_top;
  import rsmms_pkg::*;

  typedef struct packed {
    logic [31:0] count;
    logic [31:0] max_tag;
    logic [31:0] max_val;
    logic [31:0] min_tag;
    logic [31:0] min_val;
    logic [31:0] std_dev;
    logic [31:0] mean;
  } stats_t;

  typedef struct {
    logic        op;
    logic [31:0] sample;
    logic [30:0] tag;
    logic        chk;
    stats_t      res;
  } vec_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [223:0] out_tdata;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [CfgAddrWidth+1:0] cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  running_stats_min_max_stddev dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [15:0]        tol;
  logic [31:0]        st_count;
  logic signed [63:0] st_mean;
  logic [63:0]        st_msq;
  logic signed [31:0] st_min, st_max, st_min_id, st_max_id;

  stats_t expected_q[$];
  logic   chk_q[$];
  int     errors = 0;
  int     n_results = 0;
  int     n_clears = 0;
  int     n_sat = 0;
  longint cycles = 0;
  int     hold_off = 0;

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic clear_stats();
    st_count = 0;
    st_mean = 0;
    st_msq = 0;
    st_min = MIN_RESET;
    st_max = 0;
    st_min_id = ID_NONE;
    st_max_id = ID_NONE;
  endtask

  task automatic update_stats(input logic op, input logic [31:0] smp, input logic [30:0] tag,
                              output stats_t r);
    logic signed [63:0]  s, n, dm, d2, tl;
    logic signed [127:0] sq128;
    logic [63:0]         am, sq, d, v;
    if (op == OP_CLEAR) begin
      clear_stats();
    end else begin
      s = $signed(smp);
      tl = {48'd0, tol};
      if (st_count != 32'hFFFF_FFFF) st_count = st_count + 1;
      n = {32'd0, st_count};
      dm = s * 65536 - st_mean;
      st_mean = st_mean + dm / n;
      d2 = $signed(s * s) - $signed(st_msq);
      st_msq = $unsigned($signed(st_msq) + d2 / n);
      if (st_count == 1) begin
        st_max = smp; st_max_id = {1'b0, tag};
        st_min = smp; st_min_id = {1'b0, tag};
      end else if (s > 64'(st_max) + tl) begin
        st_max = smp; st_max_id = {1'b0, tag};
      end else if (s + tl < 64'(st_min)) begin
        st_min = smp; st_min_id = {1'b0, tag};
      end
    end
    r.mean = st_mean[47:16];
    if (st_count <= 1) begin
      r.std_dev = 0;
    end else begin
      am = (st_mean < 0) ? -st_mean : st_mean;
      sq128 = am * am;
      sq = sq128[95:32];
      d = (st_msq >= sq) ? st_msq - sq : sq - st_msq;
      v = d + d / ({32'd0, st_count} - 1);
      r.std_dev = 32'(isqrt(v));
    end
    r.min_val = st_min;
    r.min_tag = st_min_id;
    r.max_val = st_max;
    r.max_tag = st_max_id;
    r.count = st_count;
  endtask

  task automatic cfg_write(input logic [15:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {REG_TOLERANCE, 2'b00}; cfg_pwdata <= {16'd0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    tol = val;
  endtask

  int gap_left = 0;
  int burst_left = 0;

  // in_tvalid stays high between back-to-back beats; it drops at a gap
  task automatic send_beat(input logic op, input logic [31:0] smp, input logic [30:0] tag,
                           input logic chk, input stats_t want);
    stats_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
    end
    if (gap_left > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap_left) @(posedge clk);
    end
    gap_left = 0;
    burst_left--;
    update_stats(op, smp, tag, r);
    if (chk && r !== want) begin
      $error("table row disagrees with predictor: want %h got %h", want, r);
      errors++;
    end
    expected_q.push_back(r);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {1'b0, tag, smp};
    do @(posedge clk); while (!in_tready);
    if (op == OP_CLEAR) n_clears++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // receiver: its own stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      case ($urandom_range(7, 0))
        0, 1: out_tready <= 1'b0;
        default: out_tready <= 1'b1;
      endcase
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    stats_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        check_field("mean_out", want.mean, got.mean);
        check_field("std_dev_out", want.std_dev, got.std_dev);
        check_field("min_out", want.min_val, got.min_val);
        check_field("min_tag", want.min_tag, got.min_tag);
        check_field("max_out", want.max_val, got.max_val);
        check_field("max_tag", want.max_tag, got.max_tag);
        check_field("count_out", want.count, got.count);
        n_results++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic stats_t mk(input logic [31:0] mean, sd, mn, mnt, mx, mxt, cnt);
    stats_t r;
    r.mean = mean; r.std_dev = sd; r.min_val = mn; r.min_tag = mnt;
    r.max_val = mx; r.max_tag = mxt; r.count = cnt;
    return r;
  endfunction

  vec_t table_q[$];

  task automatic add_row(input logic op, input logic [31:0] smp, input logic [30:0] tag,
                         input logic chk, input stats_t want);
    vec_t v;
    v.op = op; v.sample = smp; v.tag = tag; v.chk = chk; v.res = want;
    table_q.push_back(v);
  endtask

  // random sample: mostly moderate values, some full range and extremes
  function automatic logic [31:0] rand_sample();
    case ($urandom_range(9, 0))
      0: return $urandom();
      1: return ($urandom_range(1, 0)) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'($signed($urandom_range(200, 0)) - 100);
      default: return 32'($signed($urandom_range(2000000, 0)) - 1000000);
    endcase
  endfunction

  initial begin
    stats_t none;
    int k, len, next_cfg;
    logic [15:0] tols[5];
    tol = 0;
    clear_stats();
    none = mk(0, 0, MIN_RESET, ID_NONE, 0, ID_NONE, 0);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    add_row(OP_CLEAR, 32'h0, 31'h0, 1'b1, none);
    add_row(OP_ADD, 32'h0001_0000, 31'd5, 1'b1,
            mk(32'h0001_0000, 0, 32'h0001_0000, 5, 32'h0001_0000, 5, 1));
    add_row(OP_ADD, 32'h0003_0000, 31'd6, 1'b0, none);
    add_row(OP_ADD, 32'hFFFF_0000, 31'd7, 1'b0, none);
    add_row(OP_ADD, 32'h0001_0000, 31'd8, 1'b0, none);
    add_row(OP_ADD, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0, none);
    add_row(OP_ADD, 32'h8000_0000, 31'h0, 1'b0, none);
    add_row(OP_ADD, 32'hFFFF_FFFF, 31'h2AAA_AAAA, 1'b0, none);
    add_row(OP_ADD, 32'h0000_0001, 31'h5555_5555, 1'b0, none);
    add_row(OP_CLEAR, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, none);
    add_row(OP_ADD, 32'h8000_0000, 31'd1, 1'b1,
            mk(32'h8000_0000, 0, 32'h8000_0000, 1, 32'h8000_0000, 1, 1));
    add_row(OP_ADD, 32'h8000_0000, 31'd2, 1'b0, none);
    add_row(OP_ADD, 32'h7FFF_FFFF, 31'd3, 1'b0, none);
    add_row(OP_CLEAR, 32'h0, 31'h0, 1'b1, none);
    add_row(OP_ADD, 32'h7FFF_FFFF, 31'd9, 1'b0, none);
    add_row(OP_ADD, 32'h7FFF_FFFF, 31'd10, 1'b0, none);
    add_row(OP_CLEAR, 32'h0, 31'h0, 1'b1, none);
    foreach (table_q[i])
      send_beat(table_q[i].op, table_q[i].sample, table_q[i].tag, table_q[i].chk,
                table_q[i].res);
    wait_idle();

    // tolerance sweep, ties near the extremes
    tols[0] = 16'hFFFF; tols[1] = 16'd1; tols[2] = 16'd0; tols[3] = 16'd300;
    tols[4] = 16'h8000;
    foreach (tols[t]) begin
      cfg_write(tols[t]);
      send_beat(OP_CLEAR, 32'h0, 31'h0, 1'b0, none);
      send_beat(OP_ADD, 32'h0, 31'd1, 1'b0, none);
      send_beat(OP_ADD, 32'(tols[t]), 31'd2, 1'b0, none);
      send_beat(OP_ADD, 32'(tols[t]) + 1, 31'd3, 1'b0, none);
      send_beat(OP_ADD, -32'(tols[t]), 31'd4, 1'b0, none);
      send_beat(OP_ADD, -32'(tols[t]) - 1, 31'd5, 1'b0, none);
      wait_idle();
    end

    // random runs between clears, tolerance changed between phases
    k = 0;
    next_cfg = 0;
    while (k < 600) begin
      if (k >= next_cfg) begin
        wait_idle();
        cfg_write($urandom_range(3, 0) == 0 ? 16'hFFFF : 16'($urandom_range(2000, 0)));
        if (next_cfg == 300) hold_off = 4000;
        next_cfg = next_cfg + 150;
      end
      len = $urandom_range(30, 1);
      for (int j = 0; j < len; j++) begin
        send_beat(OP_ADD, rand_sample(), 31'($urandom()), 1'b0, none);
        k++;
      end
      if ($urandom_range(2, 0) == 0) begin
        send_beat(OP_CLEAR, $urandom(), 31'($urandom()), 1'b0, none);
        k++;
      end
    end
    wait_idle();

    $display("%0d results checked, %0d clears, tolerance swept 0..65535, long output stall done",
             n_results, n_clears);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

[files.f]
design/rsmms_pkg.sv
design/rsmms_div.sv
design/rsmms_sqrt.sv
design/running_stats_min_max_stddev.sv
test/tb_top.sv
